[hdl/gyr_pkg.sv]
// ----------------------------------------------------------------------------
// gyr_pkg
// Shared constants and types of the periodic gyration radius block.
// ----------------------------------------------------------------------------
package gyr_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int ADDR_W        = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = ADDR_W + 1;
	localparam int NN_W          = 2 * CNT_W;
	localparam int DVD_W         = 64;
	localparam int DVS_W         = (NN_W > 32) ? NN_W : 32;
	localparam int DCNT_W        = $clog2(DVD_W + 1);
	localparam int BOX_W         = 31;
	localparam int SIZE_W        = 11;
	localparam int CFG_IDX_W     = 2;
	localparam int STEP_W        = 5;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

	localparam logic [BOX_W-1:0] BOX_RESET = 31'd655360;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               last_particle;
	} pos_t;

	typedef struct packed {
		logic [31:0]       radius;
		logic [31:0]       mean_radius;
		logic [SIZE_W-1:0] set_size;
		logic              overflow;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic              drop;
		logic [ADDR_W-1:0] addr;
		logic              lat_i;
		logic              mod_ld;
		logic              mod_step;
		logic              sq;
		logic              add1;
		logic              add2;
		logic              acc;
		logic              nn_ld;
		logic              mn_ld;
		logic              div_step;
		logic              rt_ld;
		logic              rt_step;
		logic              tot;
		logic              emit;
		logic [CNT_W-1:0]  n;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

endpackage

[hdl/gyr_div.sv]
// ----------------------------------------------------------------------------
// gyr_div
// Restoring divider, one quotient bit per cycle while step is high, 64-bit dividend.
// ----------------------------------------------------------------------------
module gyr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ld,
	input  logic                      step,
	input  logic [gyr_pkg::DVD_W-1:0] dividend,
	input  logic [gyr_pkg::DVS_W-1:0] divisor,
	output logic [gyr_pkg::DVD_W-1:0] quotient,
	output logic                      done
);
	import gyr_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DCNT_W'(DVD_W);
		end else if (ld) begin
			cnt_q <= '0;
		end else if (step && !done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (step && !done) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign quotient = dvd_q;
	assign done     = cnt_q == DCNT_W'(DVD_W);
endmodule

[hdl/gyr_dp.sv]
// ----------------------------------------------------------------------------
// gyr_dp
// Datapath: position store, box registers, minimum-image fold, pair sum,
// shared divider, square root and running totals.
// ----------------------------------------------------------------------------
module gyr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gyr_pkg::cmd_t                 cmd,
	output gyr_pkg::stat_t                stat,
	input  gyr_pkg::pos_t                 pos,
	input  logic                          cfg_valid,
	input  logic [gyr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output gyr_pkg::result_t              result,
	output logic                          done
);
	import gyr_pkg::*;

	logic [95:0]       mem [MAX_PARTICLES];
	logic [95:0]       rdata_q;
	logic [95:0]       pi_q;
	logic [BOX_W-1:0]  box_q [3];
	logic [31:0]       a_ax [3];
	logic [31:0]       b_ax [3];
	logic [31:0]       mag_q [3];
	logic [31:0]       mdv_q [3];
	logic [BOX_W-1:0]  rem_q [3];
	logic [31:0]       fold [3];
	logic [63:0]       sq_q [3];
	logic [63:0]       s_q;
	logic [63:0]       pair_sum_q;
	logic [63:0]       total_q;
	logic [31:0]       sets_q;
	logic              sat_q;
	logic              dropped_q;
	logic [63:0]       rt_v_q;
	logic [35:0]       rt_rem_q;
	logic [31:0]       root_q;
	logic [35:0]       rt_t;
	logic [35:0]       rt_trial;
	logic [NN_W-1:0]   nn;
	logic              div_ld;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic [DVD_W-1:0]  quot;
	logic              div_done;
	logic [64:0]       add_a;
	logic [64:0]       add_b;
	logic [64:0]       add_c;
	result_t           res_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0] <= BOX_RESET;
			box_q[1] <= BOX_RESET;
			box_q[2] <= BOX_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_X: box_q[0] <= cfg_data[BOX_W-1:0];
				REG_BOX_Y: box_q[1] <= cfg_data[BOX_W-1:0];
				REG_BOX_Z: box_q[2] <= cfg_data[BOX_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.addr] <= {pos.pos_x, pos.pos_y, pos.pos_z};
		end
		rdata_q <= mem[cmd.addr];
		if (cmd.lat_i) begin
			pi_q <= rdata_q;
		end
	end

	assign a_ax[0] = pi_q[95:64];
	assign a_ax[1] = pi_q[63:32];
	assign a_ax[2] = pi_q[31:0];
	assign b_ax[0] = rdata_q[95:64];
	assign b_ax[1] = rdata_q[63:32];
	assign b_ax[2] = rdata_q[31:0];

	// per-axis remainder of |d| by the box; fold is min(r, box - r), or |d| when the box is zero
	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [32:0] diff;
		logic [31:0]        mtrial;
		logic               mfits;

		assign diff   = {a_ax[k][31], a_ax[k]} - {b_ax[k][31], b_ax[k]};
		assign mtrial = {rem_q[k], mdv_q[k][31]};
		assign mfits  = mtrial >= {1'b0, box_q[k]};
		assign fold[k] = (box_q[k] == '0) ? mag_q[k] :
			(({rem_q[k], 1'b0} >= {1'b0, box_q[k]}) ? 32'(box_q[k] - rem_q[k]) :
			{1'b0, rem_q[k]});

		always_ff @(posedge clk) begin
			if (cmd.mod_ld) begin
				mag_q[k] <= diff[32] ? 32'(-diff) : diff[31:0];
				mdv_q[k] <= diff[32] ? 32'(-diff) : diff[31:0];
				rem_q[k] <= '0;
			end else if (cmd.mod_step) begin
				rem_q[k] <= mfits ? BOX_W'(mtrial - {1'b0, box_q[k]}) : mtrial[BOX_W-1:0];
				mdv_q[k] <= {mdv_q[k][30:0], 1'b0};
			end
			if (cmd.sq) begin
				sq_q[k] <= fold[k] * fold[k];
			end
		end
	end

	assign add_a = {1'b0, sq_q[0]} + {1'b0, sq_q[1]};
	assign add_b = {1'b0, s_q} + {1'b0, sq_q[2]};
	assign add_c = {1'b0, pair_sum_q} + {1'b0, s_q};

	assign nn       = cmd.n * cmd.n;
	assign div_ld   = cmd.nn_ld | cmd.mn_ld;
	assign div_dvd  = cmd.nn_ld ? pair_sum_q : total_q;
	assign div_dvs  = cmd.nn_ld ? DVS_W'(nn) : DVS_W'(sets_q);

	gyr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (div_ld),
		.step     (cmd.div_step),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quot),
		.done     (div_done)
	);

	assign stat.div_done = div_done;

	assign rt_t     = {rt_rem_q[33:0], rt_v_q[63:62]};
	assign rt_trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.add1) begin
			s_q <= add_a[64] ? '1 : add_a[63:0];
		end else if (cmd.add2) begin
			s_q <= add_b[64] ? '1 : add_b[63:0];
		end
		if (cmd.rt_ld) begin
			rt_v_q   <= quot;
			rt_rem_q <= '0;
			root_q   <= '0;
		end else if (cmd.rt_step) begin
			rt_v_q <= {rt_v_q[61:0], 2'b00};
			if (rt_t >= rt_trial) begin
				rt_rem_q <= rt_t - rt_trial;
				root_q   <= {root_q[30:0], 1'b1};
			end else begin
				rt_rem_q <= rt_t;
				root_q   <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			res_q.radius      <= root_q;
			res_q.mean_radius <= (quot[63:32] != '0) ? '1 : quot[31:0];
			res_q.set_size    <= SIZE_W'(cmd.n);
			res_q.overflow    <= dropped_q | sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_sum_q <= '0;
			total_q    <= '0;
			sets_q     <= '0;
			sat_q      <= 1'b0;
			dropped_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.drop) begin
				dropped_q <= 1'b1;
			end
			if (cmd.add1 && add_a[64]) begin
				sat_q <= 1'b1;
			end
			if (cmd.add2 && add_b[64]) begin
				sat_q <= 1'b1;
			end
			if (cmd.acc) begin
				pair_sum_q <= add_c[64] ? '1 : add_c[63:0];
				if (add_c[64]) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.tot) begin
				total_q <= (total_q > ~{32'd0, root_q}) ? '1 : total_q + {32'd0, root_q};
				if (sets_q != '1) begin
					sets_q <= sets_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				pair_sum_q <= '0;
				sat_q      <= 1'b0;
				dropped_q  <= 1'b0;
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;
endmodule

[hdl/gyr_ctrl.sv]
// ----------------------------------------------------------------------------
// gyr_ctrl
// Controller: item loading, pair walk, reduction and output sequencing.
// ----------------------------------------------------------------------------
module gyr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           last_particle,
	input  gyr_pkg::stat_t stat,
	output gyr_pkg::cmd_t  cmd,
	output logic           busy
);
	import gyr_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDI  = 4'd1;
	localparam logic [3:0] S_LDI  = 4'd2;
	localparam logic [3:0] S_RDJ  = 4'd3;
	localparam logic [3:0] S_DLD  = 4'd4;
	localparam logic [3:0] S_MOD  = 4'd5;
	localparam logic [3:0] S_SQ   = 4'd6;
	localparam logic [3:0] S_ADD1 = 4'd7;
	localparam logic [3:0] S_ADD2 = 4'd8;
	localparam logic [3:0] S_ACC  = 4'd9;
	localparam logic [3:0] S_NN   = 4'd10;
	localparam logic [3:0] S_QDIV = 4'd11;
	localparam logic [3:0] S_SQRT = 4'd12;
	localparam logic [3:0] S_TOT  = 4'd13;
	localparam logic [3:0] S_MDIV = 4'd14;
	localparam logic [3:0] S_EMIT = 4'd15;

	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_next;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [STEP_W-1:0] step_q;
	logic              accept;
	logic              full;
	logic              j_end;
	logic              i_end;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign full   = cnt_q == CNT_W'(MAX_PARTICLES);
	assign n_next = full ? cnt_q : cnt_q + 1'b1;
	assign j_end  = CNT_W'(j_q) == cnt_q - 1'b1;
	assign i_end  = CNT_W'(i_q) == cnt_q - CNT_W'(2);

	always_comb begin
		cmd     = '0;
		cmd.n   = cnt_q;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.addr = cnt_q[ADDR_W-1:0];
				if (accept) begin
					cmd.wr_en = !full;
					cmd.drop  = full;
					if (last_particle) begin
						state_d = (n_next < CNT_W'(2)) ? S_NN : S_RDI;
					end
				end
			end
			S_RDI: begin
				cmd.addr = i_q;
				state_d  = S_LDI;
			end
			S_LDI: begin
				cmd.lat_i = 1'b1;
				state_d   = S_RDJ;
			end
			S_RDJ: begin
				cmd.addr = j_q;
				state_d  = S_DLD;
			end
			S_DLD: begin
				cmd.mod_ld = 1'b1;
				state_d    = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (step_q == '1) begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				cmd.sq  = 1'b1;
				state_d = S_ADD1;
			end
			S_ADD1: begin
				cmd.add1 = 1'b1;
				state_d  = S_ADD2;
			end
			S_ADD2: begin
				cmd.add2 = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (!j_end) begin
					state_d = S_RDJ;
				end else if (i_end) begin
					state_d = S_NN;
				end else begin
					state_d = S_RDI;
				end
			end
			S_NN: begin
				cmd.nn_ld = 1'b1;
				state_d   = S_QDIV;
			end
			S_QDIV: begin
				if (stat.div_done) begin
					cmd.rt_ld = 1'b1;
					state_d   = S_SQRT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_SQRT: begin
				cmd.rt_step = 1'b1;
				if (step_q == '1) begin
					state_d = S_TOT;
				end
			end
			S_TOT: begin
				cmd.tot = 1'b1;
				state_d = S_MDIV;
			end
			S_MDIV: begin
				// first cycle loads the divider with the updated totals
				if (step_q == '0) begin
					cmd.mn_ld = 1'b1;
				end else if (stat.div_done) begin
					state_d = S_EMIT;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_EMIT) begin
				cnt_q <= '0;
			end
			if (state_q == S_IDLE) begin
				i_q <= '0;
			end else if (state_q == S_ACC && j_end) begin
				i_q <= i_q + 1'b1;
			end
			if (state_q == S_LDI) begin
				j_q <= i_q + 1'b1;
			end else if (state_q == S_ACC) begin
				j_q <= j_q + 1'b1;
			end
			if (state_q == S_MOD || state_q == S_SQRT) begin
				step_q <= step_q + 1'b1;
			end else if (state_q == S_MDIV) begin
				step_q <= '1;
			end else begin
				step_q <= '0;
			end
		end
	end
endmodule

[hdl/gyration_radius_periodic.sv]
// ----------------------------------------------------------------------------
// gyration_radius_periodic
// Gyration radius of a periodic particle set under the minimum image.
// ----------------------------------------------------------------------------
// A position that does not close the set is stored, or dropped once the store is full; busy stays low.
// A closing item holds busy through the pair walk and the reduction:
// each pair is paced by the one-bit-per-cycle box remainder,
// and the end runs a division, a square root, then the mean division.
// The result strobe lasts one cycle and cannot be stalled.
// Reset clears counters, sums and totals; the position store is not cleared.
module gyration_radius_periodic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  gyr_pkg::pos_t                 particle,
	output logic                          done,
	output gyr_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gyr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import gyr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	gyr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_particle (particle.last_particle),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy)
	);

	gyr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pos       (particle),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding computation");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.set_size != '0)
		else $error("closed set reported empty");
endmodule
